FILE: rtl/cbs_pkg.sv
// cbs_pkg: shared widths, constants, state encoding and status types for the
// cubic b-spline segment sampler; no dependencies
package cbs_pkg;

    // field and datapath widths
    localparam int COORD_W    = 12;
    localparam int SAMP_W     = 13;
    localparam int SPS_W      = 7;
    localparam int K_W        = 6;
    localparam int K2_W       = 12;
    localparam int K3_W       = 18;
    localparam int N3_W       = 19;
    localparam int WGT_W      = 21;
    localparam int WT_CALC_W  = 24;
    localparam int ACC_W      = 34;
    localparam int MULB_W     = 22;
    localparam int NUM_W      = 46;
    localparam int DEN_W      = 31;
    localparam int QUO_W      = 13;
    localparam int REM_W      = NUM_W + 1;
    localparam int CNT_W      = 4;
    localparam int J_W        = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int MAX_SAMPLES = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROJ_EN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES = 1'd1;

    localparam logic [SPS_W-1:0] SPS_RESET = SPS_W'(MAX_SAMPLES);
    localparam logic [SPS_W-1:0] MAX_N     = SPS_W'(MAX_SAMPLES);
    localparam logic [1:0]       HELD_FULL = 2'd3;

    // micro-step counter end points
    localparam logic [J_W-1:0] J_DOT_LAST  = 4'd11;
    localparam logic [J_W-1:0] J_PROJ_LAST = 4'd2;

    // multiplier constants: projection 707/1000, denominator 6 or 6000 times n^3
    localparam logic signed [MULB_W-1:0] PROJ_SCALE = 22'sd1000;
    localparam logic signed [MULB_W-1:0] PROJ_COEF  = 22'sd707;
    localparam logic signed [MULB_W-1:0] DEN_PLAIN  = 22'sd6;
    localparam logic signed [MULB_W-1:0] DEN_PROJ   = 22'sd6000;

    // output saturation
    localparam logic [QUO_W-1:0]         LIM_POS = 13'd4095;
    localparam logic [QUO_W-1:0]         LIM_NEG = 13'd4096;
    localparam logic signed [SAMP_W-1:0] SAT_HI  = 13'h0FFF;
    localparam logic signed [SAMP_W-1:0] SAT_LO  = 13'h1000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_N2,
        S_N3,
        S_DEN,
        S_DENW,
        S_K2,
        S_K3,
        S_M2,
        S_M3,
        S_K2N,
        S_WGT,
        S_DOT,
        S_DOTE,
        S_PROJ,
        S_PSUM,
        S_DSTX,
        S_DIVX,
        S_DSTY,
        S_DIVY,
        S_OUT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: rtl/cbs_mul.sv
// cbs_mul: shared signed multiplier with a registered product
// depends on cbs_pkg
module cbs_mul (
    input  logic                               i_clk,
    input  logic signed [cbs_pkg::ACC_W-1:0]   i_a,
    input  logic signed [cbs_pkg::MULB_W-1:0]  i_b,
    output logic signed [cbs_pkg::NUM_W-1:0]   o_p
);

    logic signed [cbs_pkg::ACC_W+cbs_pkg::MULB_W-1:0] full;
    logic signed [cbs_pkg::NUM_W-1:0]                  r_p;

    // full product, kept to the width the datapath ever needs
    assign full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= $signed(full[cbs_pkg::NUM_W-1:0]);
    end

    assign o_p = r_p;

endmodule

FILE: rtl/cbs_div.sv
// cbs_div: restoring divider, one quotient bit per cycle, rounds num/den to
// nearest with ties away from zero and saturates to the sample range; uses cbs_pkg
module cbs_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [cbs_pkg::NUM_W-1:0]   i_num,
    input  logic        [cbs_pkg::DEN_W-1:0]   i_den,
    output cbs_pkg::t_div_stat                 o_stat,
    output logic signed [cbs_pkg::SAMP_W-1:0]  o_quot
);

    logic [cbs_pkg::NUM_W-1:0]  mag;
    logic [cbs_pkg::REM_W-1:0]  r_rem;
    logic [cbs_pkg::REM_W-1:0]  r_dsr;
    logic [cbs_pkg::QUO_W-1:0]  r_q;
    logic                       r_neg;
    logic [cbs_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [cbs_pkg::QUO_W:0]    q_ext;
    logic [cbs_pkg::QUO_W:0]    q_neg;

    // magnitude of the numerator
    assign mag = i_num[cbs_pkg::NUM_W-1] ? $unsigned(-i_num) : $unsigned(i_num);

    // control: busy for one cycle per quotient bit, done pulse afterwards
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= cbs_pkg::CNT_W'(cbs_pkg::QUO_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // dividend 2|num| + den over divisor 2 den gives the rounded quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {mag, 1'b0} + cbs_pkg::REM_W'(i_den);
            r_dsr <= cbs_pkg::REM_W'({i_den, 1'b0}) << (cbs_pkg::QUO_W - 1);
            r_q   <= '0;
            r_neg <= i_num[cbs_pkg::NUM_W-1];
        end else if (r_busy) begin
            if (r_rem >= r_dsr) begin
                r_rem <= r_rem - r_dsr;
                r_q   <= {r_q[cbs_pkg::QUO_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[cbs_pkg::QUO_W-2:0], 1'b0};
            end
            r_dsr <= r_dsr >> 1;
        end
    end

    // sign and saturation
    assign q_ext = {1'b0, r_q};
    assign q_neg = -q_ext;

    always_comb begin
        if (r_neg) begin
            if (r_q > cbs_pkg::LIM_NEG) begin
                o_quot = cbs_pkg::SAT_LO;
            end else begin
                o_quot = $signed(q_neg[cbs_pkg::SAMP_W-1:0]);
            end
        end else begin
            if (r_q > cbs_pkg::LIM_POS) begin
                o_quot = cbs_pkg::SAT_HI;
            end else begin
                o_quot = $signed(r_q);
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

FILE: rtl/cubic_bspline_segment_sampler_top.sv
// A closing point is evaluated sample by sample, N samples per segment, by the shared
// multiplier (cbs_mul) and the bit-per-cycle divider (cbs_div), one division per output coordinate;
// projection adds steps. o_stall is high until the segment is done, so no new point is
// taken meanwhile; other points are taken without evaluation. Output stalls hold the sequence.
// Reset (synchronous, active low): window and point count cleared, projection off,
// 64 samples per segment, no item pending; no clearing pass.
module cubic_bspline_segment_sampler_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic        [cbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [cbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [cbs_pkg::COORD_W-1:0]     i_ctrl_x,
    input  logic signed [cbs_pkg::COORD_W-1:0]     i_ctrl_y,
    input  logic signed [cbs_pkg::COORD_W-1:0]     i_ctrl_z,
    input  logic                                   i_new_curve,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [cbs_pkg::SAMP_W-1:0]      o_sample_x,
    output logic signed [cbs_pkg::SAMP_W-1:0]      o_sample_y,
    output logic                                   o_last_sample
);

    cbs_pkg::t_state r_state;
    cbs_pkg::t_state n_state;

    // configuration and window
    logic                                r_proj_en;
    logic        [cbs_pkg::SPS_W-1:0]    r_sps;
    logic        [1:0]                   r_held;
    logic signed [cbs_pkg::COORD_W-1:0]  r_win_x [3];
    logic signed [cbs_pkg::COORD_W-1:0]  r_win_y [3];
    logic signed [cbs_pkg::COORD_W-1:0]  r_win_z [3];
    logic signed [cbs_pkg::COORD_W-1:0]  r_p3x;
    logic signed [cbs_pkg::COORD_W-1:0]  r_p3y;
    logic signed [cbs_pkg::COORD_W-1:0]  r_p3z;

    // sequencer counters and sample terms
    logic        [cbs_pkg::SPS_W-1:0]    r_n;
    logic        [cbs_pkg::K_W-1:0]      r_k;
    logic        [cbs_pkg::J_W-1:0]      r_j;
    logic        [cbs_pkg::N3_W-1:0]     r_n3;
    logic        [cbs_pkg::DEN_W-1:0]    r_den;
    logic        [cbs_pkg::K2_W-1:0]     r_k2;
    logic        [cbs_pkg::K3_W-1:0]     r_k3;
    logic        [cbs_pkg::N3_W-1:0]     r_m3;
    logic        [cbs_pkg::WGT_W-1:0]    r_w [4];
    logic                                r_acc_en;
    logic        [1:0]                   r_acc_c;
    logic signed [cbs_pkg::ACC_W-1:0]    r_sx;
    logic signed [cbs_pkg::ACC_W-1:0]    r_sy;
    logic signed [cbs_pkg::ACC_W-1:0]    r_sz;
    logic signed [cbs_pkg::NUM_W-1:0]    r_nx;
    logic signed [cbs_pkg::NUM_W-1:0]    r_ny;
    logic signed [cbs_pkg::SAMP_W-1:0]   r_qx;

    // output register
    logic                                r_out_vld;
    logic signed [cbs_pkg::SAMP_W-1:0]   r_out_x;
    logic signed [cbs_pkg::SAMP_W-1:0]   r_out_y;
    logic                                r_out_last;

    logic                                in_acc;
    logic        [1:0]                   held_eff;
    logic        [cbs_pkg::SPS_W-1:0]    n_eff;
    logic        [cbs_pkg::SPS_W-1:0]    m_val;
    logic                                last_k;
    logic                                out_free;
    logic                                shift_en;
    logic signed [cbs_pkg::COORD_W-1:0]  sh_x;
    logic signed [cbs_pkg::COORD_W-1:0]  sh_y;
    logic signed [cbs_pkg::COORD_W-1:0]  sh_z;
    logic signed [cbs_pkg::COORD_W-1:0]  dot_coord;
    logic signed [cbs_pkg::ACC_W-1:0]    mul_a;
    logic signed [cbs_pkg::MULB_W-1:0]   mul_b;
    logic signed [cbs_pkg::NUM_W-1:0]    mul_p;
    logic signed [cbs_pkg::WT_CALC_W-1:0] k3s;
    logic signed [cbs_pkg::WT_CALC_W-1:0] k2n;
    logic signed [cbs_pkg::WT_CALC_W-1:0] n3s;
    logic signed [cbs_pkg::WT_CALC_W-1:0] m3s;
    logic signed [cbs_pkg::WT_CALC_W-1:0] w1_s;
    logic signed [cbs_pkg::WT_CALC_W-1:0] w2_s;
    logic                                div_start;
    logic signed [cbs_pkg::NUM_W-1:0]    div_num;
    cbs_pkg::t_div_stat                  div_stat;
    logic signed [cbs_pkg::SAMP_W-1:0]   div_quot;

    // shared units
    cbs_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    cbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // small helper terms
    assign held_eff = i_new_curve ? 2'd0 : r_held;
    assign m_val    = r_n - cbs_pkg::SPS_W'(r_k);
    assign last_k   = (cbs_pkg::SPS_W'(r_k) + cbs_pkg::SPS_W'(1)) == r_n;
    assign out_free = !r_out_vld || !i_stall;

    // sample count, zero taken as one and capped at the maximum
    always_comb begin
        if (r_sps == '0) begin
            n_eff = cbs_pkg::SPS_W'(1);
        end else if (r_sps > cbs_pkg::MAX_N) begin
            n_eff = cbs_pkg::MAX_N;
        end else begin
            n_eff = r_sps;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: next state and handshake/unit controls
    always_comb begin
        n_state   = r_state;
        o_stall   = (r_state != cbs_pkg::S_IDLE);
        in_acc    = i_valid && (r_state == cbs_pkg::S_IDLE);
        div_start = (r_state == cbs_pkg::S_DSTX) || (r_state == cbs_pkg::S_DSTY);
        unique case (r_state)
            cbs_pkg::S_IDLE: begin
                if (in_acc && (held_eff == cbs_pkg::HELD_FULL)) begin
                    n_state = cbs_pkg::S_N2;
                end
            end
            cbs_pkg::S_N2:   n_state = cbs_pkg::S_N3;
            cbs_pkg::S_N3:   n_state = cbs_pkg::S_DEN;
            cbs_pkg::S_DEN:  n_state = cbs_pkg::S_DENW;
            cbs_pkg::S_DENW: n_state = cbs_pkg::S_K2;
            cbs_pkg::S_K2:   n_state = cbs_pkg::S_K3;
            cbs_pkg::S_K3:   n_state = cbs_pkg::S_M2;
            cbs_pkg::S_M2:   n_state = cbs_pkg::S_M3;
            cbs_pkg::S_M3:   n_state = cbs_pkg::S_K2N;
            cbs_pkg::S_K2N:  n_state = cbs_pkg::S_WGT;
            cbs_pkg::S_WGT:  n_state = cbs_pkg::S_DOT;
            cbs_pkg::S_DOT: begin
                if (r_j == cbs_pkg::J_DOT_LAST) begin
                    n_state = cbs_pkg::S_DOTE;
                end
            end
            cbs_pkg::S_DOTE: n_state = r_proj_en ? cbs_pkg::S_PROJ : cbs_pkg::S_DSTX;
            cbs_pkg::S_PROJ: begin
                if (r_j == cbs_pkg::J_PROJ_LAST) begin
                    n_state = cbs_pkg::S_PSUM;
                end
            end
            cbs_pkg::S_PSUM: n_state = cbs_pkg::S_DSTX;
            cbs_pkg::S_DSTX: n_state = cbs_pkg::S_DIVX;
            cbs_pkg::S_DIVX: begin
                if (div_stat.done) begin
                    n_state = cbs_pkg::S_DSTY;
                end
            end
            cbs_pkg::S_DSTY: n_state = cbs_pkg::S_DIVY;
            cbs_pkg::S_DIVY: begin
                if (div_stat.done) begin
                    n_state = cbs_pkg::S_OUT;
                end
            end
            cbs_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = last_k ? cbs_pkg::S_FIN : cbs_pkg::S_K2;
                end
            end
            cbs_pkg::S_FIN:  n_state = cbs_pkg::S_IDLE;
            default:         n_state = cbs_pkg::S_IDLE;
        endcase
    end

    // coordinate for the current weight product
    always_comb begin
        case (r_j[1:0])
            2'd0: begin
                sh_x = r_win_x[0];
                sh_y = r_win_y[0];
                sh_z = r_win_z[0];
            end
            2'd1: begin
                sh_x = r_win_x[1];
                sh_y = r_win_y[1];
                sh_z = r_win_z[1];
            end
            2'd2: begin
                sh_x = r_win_x[2];
                sh_y = r_win_y[2];
                sh_z = r_win_z[2];
            end
            default: begin
                sh_x = r_p3x;
                sh_y = r_p3y;
                sh_z = r_p3z;
            end
        endcase
        case (r_j[3:2])
            2'd0:    dot_coord = sh_x;
            2'd1:    dot_coord = sh_y;
            default: dot_coord = sh_z;
        endcase
    end

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            cbs_pkg::S_N2: begin
                mul_a = cbs_pkg::ACC_W'(r_n);
                mul_b = cbs_pkg::MULB_W'(r_n);
            end
            cbs_pkg::S_N3: begin
                mul_a = cbs_pkg::ACC_W'(mul_p);
                mul_b = cbs_pkg::MULB_W'(r_n);
            end
            cbs_pkg::S_DEN: begin
                mul_a = cbs_pkg::ACC_W'(mul_p);
                mul_b = r_proj_en ? cbs_pkg::DEN_PROJ : cbs_pkg::DEN_PLAIN;
            end
            cbs_pkg::S_K2: begin
                mul_a = cbs_pkg::ACC_W'(r_k);
                mul_b = cbs_pkg::MULB_W'(r_k);
            end
            cbs_pkg::S_K3: begin
                mul_a = cbs_pkg::ACC_W'(mul_p);
                mul_b = cbs_pkg::MULB_W'(r_k);
            end
            cbs_pkg::S_M2: begin
                mul_a = cbs_pkg::ACC_W'(m_val);
                mul_b = cbs_pkg::MULB_W'(m_val);
            end
            cbs_pkg::S_M3: begin
                mul_a = cbs_pkg::ACC_W'(mul_p);
                mul_b = cbs_pkg::MULB_W'(m_val);
            end
            cbs_pkg::S_K2N: begin
                mul_a = cbs_pkg::ACC_W'(r_k2);
                mul_b = cbs_pkg::MULB_W'(r_n);
            end
            cbs_pkg::S_DOT: begin
                mul_a = cbs_pkg::ACC_W'(dot_coord);
                mul_b = cbs_pkg::MULB_W'(r_w[r_j[1:0]]);
            end
            cbs_pkg::S_PROJ: begin
                case (r_j[1:0])
                    2'd0: begin
                        mul_a = r_sx;
                        mul_b = cbs_pkg::PROJ_SCALE;
                    end
                    2'd1: begin
                        mul_a = r_sy;
                        mul_b = cbs_pkg::PROJ_SCALE;
                    end
                    default: begin
                        mul_a = r_sz;
                        mul_b = cbs_pkg::PROJ_COEF;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // weights from k^3, k^2*n (in the product register), n^3 and (n-k)^3
    assign k3s  = cbs_pkg::WT_CALC_W'(r_k3);
    assign k2n  = cbs_pkg::WT_CALC_W'(mul_p);
    assign n3s  = cbs_pkg::WT_CALC_W'(r_n3);
    assign m3s  = cbs_pkg::WT_CALC_W'(r_m3);
    assign w1_s = (k3s <<< 1) + k3s - ((k2n <<< 2) + (k2n <<< 1)) + (n3s <<< 2);
    assign w2_s = (n3s <<< 2) + (n3s <<< 1) - m3s - w1_s - k3s;

    // divider numerator: plain sums or projected sums
    always_comb begin
        if (r_state == cbs_pkg::S_DSTY) begin
            div_num = r_proj_en ? r_ny : cbs_pkg::NUM_W'(r_sy);
        end else begin
            div_num = r_proj_en ? r_nx : cbs_pkg::NUM_W'(r_sx);
        end
    end

    // window shift source
    assign shift_en = (in_acc && (held_eff != cbs_pkg::HELD_FULL))
                   || (r_state == cbs_pkg::S_FIN);

    // control registers, window and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj_en <= 1'b0;
            r_sps     <= cbs_pkg::SPS_RESET;
            r_held    <= '0;
            r_out_vld <= 1'b0;
            r_acc_en  <= 1'b0;
            r_k       <= '0;
            r_j       <= '0;
            for (int i = 0; i < 3; i++) begin
                r_win_x[i] <= '0;
                r_win_y[i] <= '0;
                r_win_z[i] <= '0;
            end
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    cbs_pkg::CFG_PROJ_EN: r_proj_en <= i_cfg_data[0];
                    cbs_pkg::CFG_SAMPLES: r_sps     <= i_cfg_data;
                endcase
            end

            // points held in the current curve
            if (in_acc) begin
                r_held <= (held_eff == cbs_pkg::HELD_FULL) ? cbs_pkg::HELD_FULL
                                                           : held_eff + 2'd1;
            end

            // window shifts in the new point, or the held closing point at segment end, oldest first
            if (shift_en) begin
                r_win_x[0] <= r_win_x[1];
                r_win_x[1] <= r_win_x[2];
                r_win_y[0] <= r_win_y[1];
                r_win_y[1] <= r_win_y[2];
                r_win_z[0] <= r_win_z[1];
                r_win_z[1] <= r_win_z[2];
                if (r_state == cbs_pkg::S_FIN) begin
                    r_win_x[2] <= r_p3x;
                    r_win_y[2] <= r_p3y;
                    r_win_z[2] <= r_p3z;
                end else begin
                    r_win_x[2] <= i_ctrl_x;
                    r_win_y[2] <= i_ctrl_y;
                    r_win_z[2] <= i_ctrl_z;
                end
            end

            // sample index
            if (r_state == cbs_pkg::S_DENW) begin
                r_k <= '0;
            end else if ((r_state == cbs_pkg::S_OUT) && out_free && !last_k) begin
                r_k <= r_k + 1'b1;
            end

            // micro-step counter for products
            if ((r_state == cbs_pkg::S_WGT) || (r_state == cbs_pkg::S_DOTE)) begin
                r_j <= '0;
            end else if ((r_state == cbs_pkg::S_DOT) || (r_state == cbs_pkg::S_PROJ)) begin
                r_j <= r_j + 1'b1;
            end

            r_acc_en <= (r_state == cbs_pkg::S_DOT);

            // output slot
            if ((r_state == cbs_pkg::S_OUT) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc_c <= r_j[3:2];

        if (in_acc) begin
            r_p3x <= i_ctrl_x;
            r_p3y <= i_ctrl_y;
            r_p3z <= i_ctrl_z;
            r_n   <= n_eff;
        end

        // products appear in the product register in the state after issue
        case (r_state)
            cbs_pkg::S_DEN:  r_n3  <= cbs_pkg::N3_W'(mul_p);
            cbs_pkg::S_DENW: r_den <= cbs_pkg::DEN_W'(mul_p);
            cbs_pkg::S_K3:   r_k2  <= cbs_pkg::K2_W'(mul_p);
            cbs_pkg::S_M2:   r_k3  <= cbs_pkg::K3_W'(mul_p);
            cbs_pkg::S_K2N:  r_m3  <= cbs_pkg::N3_W'(mul_p);
            cbs_pkg::S_WGT: begin
                r_w[0] <= cbs_pkg::WGT_W'(r_m3);
                r_w[1] <= cbs_pkg::WGT_W'(w1_s);
                r_w[2] <= cbs_pkg::WGT_W'(w2_s);
                r_w[3] <= cbs_pkg::WGT_W'(r_k3);
            end
            cbs_pkg::S_PROJ: begin
                if (r_j == 4'd1) begin
                    r_nx <= mul_p;
                end else if (r_j == cbs_pkg::J_PROJ_LAST) begin
                    r_ny <= mul_p;
                end
            end
            cbs_pkg::S_PSUM: begin
                r_nx <= r_nx + mul_p;
                r_ny <= r_ny + mul_p;
            end
            default: begin
            end
        endcase

        // weighted sums per coordinate
        if (r_state == cbs_pkg::S_WGT) begin
            r_sx <= '0;
            r_sy <= '0;
            r_sz <= '0;
        end else if (r_acc_en) begin
            case (r_acc_c)
                2'd0:    r_sx <= r_sx + cbs_pkg::ACC_W'(mul_p);
                2'd1:    r_sy <= r_sy + cbs_pkg::ACC_W'(mul_p);
                default: r_sz <= r_sz + cbs_pkg::ACC_W'(mul_p);
            endcase
        end

        if ((r_state == cbs_pkg::S_DIVX) && div_stat.done) begin
            r_qx <= div_quot;
        end

        if ((r_state == cbs_pkg::S_OUT) && out_free) begin
            r_out_x    <= r_qx;
            r_out_y    <= div_quot;
            r_out_last <= last_k;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_sample_x    = r_out_x;
    assign o_sample_y    = r_out_y;
    assign o_last_sample = r_out_last;

`ifndef SYNTHESIS
    a_full_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cbs_pkg::S_IDLE) |-> (r_held == cbs_pkg::HELD_FULL))
        else $error("segment evaluation without a full window");

    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cbs_pkg::S_IDLE) |-> ((r_n != '0) && (r_n <= cbs_pkg::MAX_N)))
        else $error("sample count out of range during evaluation");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cbs_pkg::S_OUT) |-> (cbs_pkg::SPS_W'(r_k) < r_n))
        else $error("sample index beyond sample count");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");
`endif

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for cubic_bspline_segment_sampler_top
// exact-integer segment sampler prediction, random idling on both channels
// depends on cbs_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 150;
    localparam int STALL_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 130;

    localparam logic signed [cbs_pkg::COORD_W-1:0] COORD_MIN = -2048;
    localparam logic signed [cbs_pkg::COORD_W-1:0] COORD_MAX = 2047;

    typedef struct {
        logic signed [cbs_pkg::SAMP_W-1:0] x;
        logic signed [cbs_pkg::SAMP_W-1:0] y;
        logic                              last;
    } t_sample;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_cfg_we;
    logic [cbs_pkg::CFG_IDX_W-1:0]        i_cfg_index;
    logic [cbs_pkg::CFG_DATA_W-1:0]       i_cfg_data;
    logic                                 i_valid;
    logic                                 o_stall;
    logic signed [cbs_pkg::COORD_W-1:0]   i_ctrl_x;
    logic signed [cbs_pkg::COORD_W-1:0]   i_ctrl_y;
    logic signed [cbs_pkg::COORD_W-1:0]   i_ctrl_z;
    logic                                 i_new_curve;
    logic                                 o_valid;
    logic                                 i_stall;
    logic signed [cbs_pkg::SAMP_W-1:0]    o_sample_x;
    logic signed [cbs_pkg::SAMP_W-1:0]    o_sample_y;
    logic                                 o_last_sample;

    // predictor state: control point window, curve fill count, register copies
    logic signed [cbs_pkg::COORD_W-1:0] win_x [3] = '{0, 0, 0};
    logic signed [cbs_pkg::COORD_W-1:0] win_y [3] = '{0, 0, 0};
    logic signed [cbs_pkg::COORD_W-1:0] win_z [3] = '{0, 0, 0};
    int                                 points_held   = 0;
    logic                               proj_setting  = 1'b0;
    logic [cbs_pkg::CFG_DATA_W-1:0]     count_setting = cbs_pkg::SPS_RESET;

    t_sample expected_samples [$];
    int      err_count    = 0;
    int      random_items = 0;
    bit      no_gaps      = 1'b0;
    bit      hold_request = 1'b0;

    cubic_bspline_segment_sampler_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ctrl_x      (i_ctrl_x),
        .i_ctrl_y      (i_ctrl_y),
        .i_ctrl_z      (i_ctrl_z),
        .i_new_curve   (i_new_curve),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sample_x    (o_sample_x),
        .o_sample_y    (o_sample_y),
        .o_last_sample (o_last_sample)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // divide with rounding to nearest, ties away from zero (den > 0)
    function automatic longint round_half_away(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic logic signed [cbs_pkg::SAMP_W-1:0] clamp_sample(longint v);
        if (v > 4095) return cbs_pkg::SAT_HI;
        if (v < -4096) return cbs_pkg::SAT_LO;
        return cbs_pkg::SAMP_W'(v);
    endfunction

    // expected samples of one accepted control point, then window shift
    task automatic predict_segment_samples(
            input logic signed [cbs_pkg::COORD_W-1:0] px, py, pz,
            input logic restart);
        longint  n, n3, k, m, sx, sy, sz, nx, ny, den;
        longint  w [4];
        longint  cx [4];
        longint  cy [4];
        longint  cz [4];
        t_sample s;
        int      i;
        if (restart) points_held = 0;
        if (points_held >= 3) begin
            n = longint'(count_setting);
            if (n < 1) n = 1;
            if (n > cbs_pkg::MAX_SAMPLES) n = cbs_pkg::MAX_SAMPLES;
            n3 = n * n * n;
            for (i = 0; i < 3; i++) begin
                cx[i] = win_x[i];
                cy[i] = win_y[i];
                cz[i] = win_z[i];
            end
            cx[3] = px;
            cy[3] = py;
            cz[3] = pz;
            for (k = 0; k < n; k++) begin
                // basis weights scaled by 6 n^3
                m    = n - k;
                w[0] = m * m * m;
                w[1] = 3 * k * k * k - 6 * k * k * n + 4 * n3;
                w[2] = -3 * k * k * k + 3 * k * k * n + 3 * k * n * n + n3;
                w[3] = k * k * k;
                sx = 0;
                sy = 0;
                sz = 0;
                for (i = 0; i < 4; i++) begin
                    sx += w[i] * cx[i];
                    sy += w[i] * cy[i];
                    sz += w[i] * cz[i];
                end
                if (proj_setting) begin
                    nx  = 1000 * sx + 707 * sz;
                    ny  = 1000 * sy + 707 * sz;
                    den = 6000 * n3;
                end else begin
                    nx  = sx;
                    ny  = sy;
                    den = 6 * n3;
                end
                s.x    = clamp_sample(round_half_away(nx, den));
                s.y    = clamp_sample(round_half_away(ny, den));
                s.last = (k == n - 1);
                expected_samples = {expected_samples, s};
            end
        end
        win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = px;
        win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = py;
        win_z[0] = win_z[1]; win_z[1] = win_z[2]; win_z[2] = pz;
        if (points_held < 3) points_held++;
    endtask

    // input side: predict on every accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            predict_segment_samples(i_ctrl_x, i_ctrl_y, i_ctrl_z, i_new_curve);
    end

    // output side: compare every accepted sample with the oldest expectation
    always @(posedge i_clk) begin
        t_sample s;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected sample: x %0d y %0d last %0b",
                       o_sample_x, o_sample_y, o_last_sample);
                err_count++;
            end else begin
                s = expected_samples.pop_front();
                if (o_sample_x !== s.x) begin
                    $error("sample_x mismatch: expected %0d, got %0d", s.x, o_sample_x);
                    err_count++;
                end
                if (o_sample_y !== s.y) begin
                    $error("sample_y mismatch: expected %0d, got %0d", s.y, o_sample_y);
                    err_count++;
                end
                if (o_last_sample !== s.last) begin
                    $error("last_sample mismatch: expected %0b, got %0b",
                           s.last, o_last_sample);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // mostly short gaps, a few long ones, none in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (no_gaps || r < 11) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stall pattern, with one long hold-off on request
    initial begin : sample_sink
        int run;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                run = HOLD_CYCLES;
            end else if (no_gaps) begin
                i_stall <= 1'b0;
                run = 1;
            end else begin
                i_stall <= ($urandom_range(0, 2) == 0);
                run = pick_gap() + 1;
            end
            repeat (run - 1) @(negedge i_clk);
        end
    end

    function automatic logic signed [cbs_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            default: return cbs_pkg::COORD_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // offer one control point item and hold it until taken
    task automatic send_point(input logic signed [cbs_pkg::COORD_W-1:0] px, py, pz,
                              input logic restart);
        int gap;
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_ctrl_x    <= px;
        i_ctrl_y    <= py;
        i_ctrl_z    <= pz;
        i_new_curve <= restart;
        do @(posedge i_clk); while (o_stall);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [cbs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cbs_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == cbs_pkg::CFG_PROJ_EN)
            proj_setting = data[0];
        else
            count_setting = data;
    endtask

    // projection enable with random don't-care upper bits
    task automatic write_projection(input logic en);
        write_reg(cbs_pkg::CFG_PROJ_EN, {6'($urandom_range(0, 63)), en});
    endtask

    // stop offering, wait for all samples and let the block settle
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // reset settings: 64 samples, no projection, extreme coordinates
    task automatic test_default_config();
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MAX, '0, 1'b0);
        send_point(COORD_MAX, COORD_MIN, cbs_pkg::COORD_W'(-1), 1'b0);
        send_point('0, '0, '0, 1'b0);
        wait_for_drain();
    endtask

    // sample count of zero acts as one, above the maximum is capped
    task automatic test_sample_count_limits();
        write_reg(cbs_pkg::CFG_SAMPLES, '0);
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        wait_for_drain();
        write_reg(cbs_pkg::CFG_SAMPLES, 7'd127);
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        wait_for_drain();
    endtask

    // projection on, largest and smallest points at full sample count
    task automatic test_projection();
        write_reg(cbs_pkg::CFG_SAMPLES, cbs_pkg::MAX_N);
        write_projection(1'b1);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        wait_for_drain();
    endtask

    // new curve flag while filling, on a closing point, and after it
    task automatic test_new_curve();
        write_projection(1'b0);
        write_reg(cbs_pkg::CFG_SAMPLES, 7'd3);
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
        wait_for_drain();
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_output_hold();
        int i;
        write_reg(cbs_pkg::CFG_SAMPLES, 7'd4);
        write_projection(1'b1);
        no_gaps      = 1'b1;
        hold_request = 1'b1;
        for (i = 0; i < 12; i++)
            send_point(rand_coord(), rand_coord(), rand_coord(), i == 0);
        no_gaps = 1'b0;
        wait_for_drain();
    endtask

    // random phases of mostly well-formed curves under varied settings
    task automatic test_random_curves();
        int                             phase_len;
        int                             big_phases;
        int                             i;
        logic                           big;
        logic                           restart;
        logic [cbs_pkg::CFG_DATA_W-1:0] n_pick;
        big_phases = 0;
        while (random_items < RANDOM_ITEMS) begin
            big = 1'b0;
            case ($urandom_range(0, 9))
                0: begin
                    if (big_phases < 2) begin
                        n_pick = (big_phases == 0)
                               ? cbs_pkg::MAX_N
                               : cbs_pkg::CFG_DATA_W'($urandom_range(65, 127));
                        big = 1'b1;
                        big_phases++;
                    end else begin
                        n_pick = cbs_pkg::CFG_DATA_W'($urandom_range(1, 8));
                    end
                end
                1, 2:    n_pick = cbs_pkg::CFG_DATA_W'($urandom_range(9, 20));
                3:       n_pick = '0;
                default: n_pick = cbs_pkg::CFG_DATA_W'($urandom_range(1, 8));
            endcase
            write_reg(cbs_pkg::CFG_SAMPLES, n_pick);
            write_projection(1'($urandom_range(0, 1)));
            no_gaps   = ($urandom_range(0, 3) == 0);
            phase_len = big ? 6 : $urandom_range(10, 25);
            for (i = 0; i < phase_len; i++) begin
                restart = (i == 0) ? 1'($urandom_range(0, 1))
                                   : ($urandom_range(0, 15) == 0);
                send_point(rand_coord(), rand_coord(), rand_coord(), restart);
                random_items++;
            end
            no_gaps = 1'b0;
            wait_for_drain();
        end
    endtask

    // reset, test sequence, verdict
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_ctrl_x    = '0;
        i_ctrl_y    = '0;
        i_ctrl_z    = '0;
        i_new_curve = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_config();
        test_sample_count_limits();
        test_projection();
        test_new_curve();
        test_output_hold();
        test_random_curves();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
rtl/cbs_pkg.sv
rtl/cbs_mul.sv
rtl/cbs_div.sv
rtl/cubic_bspline_segment_sampler_top.sv
dv/tb_top.sv
